// ===== rtl/pfx_pkg.sv =====
`timescale 1ns / 1ps
package pfx_pkg;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expr;
  } sym_beat_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } res_beat_t;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_SLASH = 8'd47;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADCHAR = 3'd1;
  localparam logic [2:0] ST_UNDER   = 3'd2;
  localparam logic [2:0] ST_OVER    = 3'd3;
  localparam logic [2:0] ST_DIVZERO = 3'd4;

endpackage

// ===== rtl/pfx_ram.sv =====
`timescale 1ns / 1ps
module pfx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pfx_div.sv =====
`timescale 1ns / 1ps
module pfx_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quot
);

  localparam int NB = 32;
  localparam int CNTW = $clog2(NB);

  logic            run;
  logic [CNTW-1:0] cnt;
  logic [31:0]     rem;
  logic [31:0]     quo;
  logic [31:0]     dm;
  logic            neg;

  logic [32:0] sh;
  logic [32:0] diff;
  logic        step_bit;
  logic [31:0] step_rem;
  logic [31:0] num_mag;
  logic [31:0] den_mag;

  // signed operands become magnitudes; sign is restored on the way out
  assign num_mag  = num[31] ? (~num + 32'd1) : num;
  assign den_mag  = den[31] ? (~den + 32'd1) : den;
  assign sh       = {rem, quo[31]};
  assign diff     = sh - {1'b0, dm};
  assign step_bit = ~diff[32];
  assign step_rem = step_bit ? diff[31:0] : sh[31:0];
  assign quot     = neg ? (~quo + 32'd1) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == CNTW'(NB - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      rem <= '0;
      quo <= num_mag;
      dm  <= den_mag;
      neg <= num[31] ^ den[31];
    end else if (run) begin
      cnt <= cnt + CNTW'(1);
      rem <= step_rem;
      quo <= {quo[30:0], step_bit};
    end
  end

endmodule

// ===== rtl/postfix_expression_evaluator_unit.sv =====
`timescale 1ns / 1ps
// Postfix evaluator: stack entries live in a one-read one-write RAM, top of stack in a register.
// Digit or bad character: accepted in S_IDLE. +, -, *: accept, read/compute (S_CALC), write back (S_WB).
// /: a nonzero divisor adds the 32-step bit-serial divider (S_DIV) before write back.
// End of expression adds S_FIN to load the result register; a result beat waits there.
// Reset (rst, synchronous, active high) empties the stack and clears the sticky status.
module postfix_expression_evaluator_unit #(
  parameter int STACK_DEPTH = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sym_valid,
  output logic               sym_ready,
  input  pfx_pkg::sym_beat_t sym_data,
  output logic               res_valid,
  input  logic               res_ready,
  output pfx_pkg::res_beat_t res_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_CALC, S_DIV, S_WB, S_FIN} state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [2:0]    err;
  logic [31:0]   tos;
  logic [7:0]    op;
  logic          last;
  logic [31:0]   res;

  logic          accept;
  logic          is_digit;
  logic          is_op;
  logic          has1;
  logic          has2;
  logic          full;
  logic [CW-1:0] cnt_m2;
  logic [31:0]   right;
  logic [31:0]   left;
  logic [31:0]   prod;
  logic [7:0]    digit_val;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re;
  logic [31:0]   ram_rdata;

  logic          div_start;
  logic          div_done;
  logic [31:0]   div_quot;

  assign sym_ready = (state == S_IDLE);
  assign accept    = sym_valid && sym_ready;
  assign is_digit  = (sym_data.symbol >= pfx_pkg::CH_ZERO) &&
                     (sym_data.symbol <= pfx_pkg::CH_NINE);
  assign is_op     = (sym_data.symbol == pfx_pkg::CH_PLUS)  ||
                     (sym_data.symbol == pfx_pkg::CH_MINUS) ||
                     (sym_data.symbol == pfx_pkg::CH_STAR)  ||
                     (sym_data.symbol == pfx_pkg::CH_SLASH);
  assign digit_val = sym_data.symbol - pfx_pkg::CH_ZERO;

  assign has1   = (count != '0);
  assign has2   = (count >= CW'(2));
  assign full   = (count >= CW'(STACK_DEPTH));
  assign cnt_m2 = count - CW'(2);

  // missing operands read as all ones
  assign right = has1 ? tos : '1;
  assign left  = has2 ? ram_rdata : '1;
  assign prod  = left * right;

  assign ram_re    = accept && is_op;
  assign ram_we    = (accept && is_digit && !full) || (state == S_WB);
  assign ram_waddr = (state == S_WB) ? (has2 ? cnt_m2[AW-1:0] : '0) : count[AW-1:0];
  assign ram_wdata = (state == S_WB) ? res : {24'd0, digit_val};

  assign div_start = (state == S_CALC) && (op == pfx_pkg::CH_SLASH) && (right != '0);

  pfx_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  pfx_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (left),
    .den   (right),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      err       <= pfx_pkg::ST_OK;
      res_valid <= 1'b0;
    end else begin
      if (state == S_FIN && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op   <= sym_data.symbol;
            last <= sym_data.end_of_expr;
            if (is_op) begin
              state <= S_CALC;
            end else begin
              if (is_digit) begin
                if (!full) begin
                  count <= count + CW'(1);
                  tos   <= {24'd0, digit_val};
                end else if (err == pfx_pkg::ST_OK) begin
                  err <= pfx_pkg::ST_OVER;
                end
              end else if (err == pfx_pkg::ST_OK) begin
                err <= pfx_pkg::ST_BADCHAR;
              end
              state <= sym_data.end_of_expr ? S_FIN : S_IDLE;
            end
          end
        end
        S_CALC: begin
          if (err == pfx_pkg::ST_OK) begin
            if (!has2) begin
              err <= pfx_pkg::ST_UNDER;
            end else if (op == pfx_pkg::CH_SLASH && right == '0) begin
              err <= pfx_pkg::ST_DIVZERO;
            end
          end
          case (op)
            pfx_pkg::CH_PLUS:  res <= left + right;
            pfx_pkg::CH_MINUS: res <= left - right;
            pfx_pkg::CH_STAR:  res <= prod;
            default:           res <= '0;
          endcase
          state <= div_start ? S_DIV : S_WB;
        end
        S_DIV: begin
          if (div_done) begin
            res   <= div_quot;
            state <= S_WB;
          end
        end
        S_WB: begin
          // two pops and a push: net one fewer, never below one
          count <= has2 ? (count - CW'(1)) : CW'(1);
          tos   <= res;
          state <= last ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (!res_valid || res_ready) begin
            res_data.value  <= has1 ? tos : '1;
            res_data.status <= (err != pfx_pkg::ST_OK) ? err :
                               (has1 ? pfx_pkg::ST_OK : pfx_pkg::ST_UNDER);
            count           <= '0;
            err             <= pfx_pkg::ST_OK;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!res_valid || res_ready)) |=>
      (res_valid && count == '0 && err == pfx_pkg::ST_OK && state == S_IDLE))
    else $error("result beat not issued or stack not cleared");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (right != '0 && state == S_CALC))
    else $error("divider started with zero divisor");

  a_wb_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB) |=> (count != '0))
    else $error("stack empty after write back");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int STACK_DEPTH  = 10;
  localparam int RANDOM_BEATS = 1800;
  localparam int TAIL_BEATS   = 250;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_PRINTS   = 40;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               sym_valid = 1'b0;
  logic               sym_ready;
  pfx_pkg::sym_beat_t sym_data  = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  pfx_pkg::res_beat_t res_data;

  postfix_expression_evaluator_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .sym_valid(sym_valid),
    .sym_ready(sym_ready),
    .sym_data (sym_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  always #2 clk = ~clk;

  // Expected evaluator state
  logic [31:0] calc_stack [STACK_DEPTH];
  int          calc_depth = 0;
  logic [2:0]  calc_err   = pfx_pkg::ST_OK;

  pfx_pkg::sym_beat_t pend_q [$];
  pfx_pkg::res_beat_t results_due [$];
  pfx_pkg::res_beat_t due;

  int fault_count     = 0;
  int beats_sent      = 0;
  int expr_count      = 0;
  int results_seen    = 0;
  int flagged_results = 0;
  int gap_left        = 0;
  int gap_pct         = 10;
  int stall_left      = 0;
  int stall_pct       = 10;
  int idle_cycles     = 0;
  logic steady_tail   = 1'b0;

  task automatic log_mismatch(input string msg);
    fault_count++;
    if (fault_count <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic keep_error(input logic [2:0] code);
    if (calc_err == pfx_pkg::ST_OK) calc_err = code;
  endtask

  task automatic push_value(input logic [31:0] v);
    if (calc_depth < STACK_DEPTH) begin
      calc_stack[calc_depth] = v;
      calc_depth++;
    end else begin
      keep_error(pfx_pkg::ST_OVER);
    end
  endtask

  task automatic pop_value(output logic [31:0] v);
    if (calc_depth == 0) begin
      keep_error(pfx_pkg::ST_UNDER);
      v = '1;
    end else begin
      calc_depth--;
      v = calc_stack[calc_depth];
    end
  endtask

  task automatic evaluate_symbol(input pfx_pkg::sym_beat_t b);
    logic [31:0] rhs, lhs, acc, nmag, dmag, quo;
    pfx_pkg::res_beat_t outcome;
    if (b.symbol >= pfx_pkg::CH_ZERO && b.symbol <= pfx_pkg::CH_NINE) begin
      push_value({24'd0, b.symbol - pfx_pkg::CH_ZERO});
    end else if (b.symbol == pfx_pkg::CH_PLUS || b.symbol == pfx_pkg::CH_MINUS ||
                 b.symbol == pfx_pkg::CH_STAR || b.symbol == pfx_pkg::CH_SLASH) begin
      // right operand comes off first
      pop_value(rhs);
      pop_value(lhs);
      case (b.symbol)
        pfx_pkg::CH_PLUS:  acc = lhs + rhs;
        pfx_pkg::CH_MINUS: acc = lhs - rhs;
        pfx_pkg::CH_STAR:  acc = lhs * rhs;
        default: begin
          if (rhs == '0) begin
            keep_error(pfx_pkg::ST_DIVZERO);
            acc = '0;
          end else begin
            // divide magnitudes, then fix the sign: truncates toward zero
            nmag = lhs[31] ? -lhs : lhs;
            dmag = rhs[31] ? -rhs : rhs;
            quo  = nmag / dmag;
            acc  = (lhs[31] ^ rhs[31]) ? -quo : quo;
          end
        end
      endcase
      push_value(acc);
    end else begin
      keep_error(pfx_pkg::ST_BADCHAR);
    end
    if (b.end_of_expr) begin
      if (calc_depth == 0) begin
        keep_error(pfx_pkg::ST_UNDER);
        outcome.value = '1;
      end else begin
        outcome.value = calc_stack[calc_depth - 1];
      end
      outcome.status = calc_err;
      results_due.push_back(outcome);
      calc_depth = 0;
      calc_err   = pfx_pkg::ST_OK;
    end
  endtask

  // Stimulus builders
  function automatic logic [7:0] digit_ch(input int n);
    return pfx_pkg::CH_ZERO + 8'(n);
  endfunction

  function automatic logic [7:0] any_op();
    case ($urandom_range(0, 3))
      0:       return pfx_pkg::CH_PLUS;
      1:       return pfx_pkg::CH_MINUS;
      2:       return pfx_pkg::CH_STAR;
      default: return pfx_pkg::CH_SLASH;
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 8;
      2:       return 25;
      default: return 50;
    endcase
  endfunction

  task automatic emit(input logic [7:0] s);
    pfx_pkg::sym_beat_t b;
    b.symbol      = s;
    b.end_of_expr = 1'b0;
    pend_q.push_back(b);
  endtask

  task automatic close_expr();
    pfx_pkg::sym_beat_t b;
    b = pend_q.pop_back();
    b.end_of_expr = 1'b1;
    pend_q.push_back(b);
    expr_count++;
  endtask

  task automatic emit_wellformed();
    int n_dig, used, d, bias;
    n_dig = $urandom_range(1, 14);
    bias  = $urandom_range(1, 3);
    used  = 0;
    d     = 0;
    while (used < n_dig || d > 1) begin
      if (used < n_dig &&
          (d < 2 || (d < STACK_DEPTH && $urandom_range(0, 3) < bias))) begin
        emit(digit_ch($urandom_range(0, 9)));
        used++;
        d++;
      end else begin
        emit(any_op());
        d--;
      end
    end
    close_expr();
  endtask

  // Too many pushes or pops: drives overflow and underflow
  task automatic emit_broken();
    int pushes, pops, k;
    pushes = $urandom_range(0, 14);
    pops   = $urandom_range(0, 12);
    if (pushes + pops == 0) pushes = 1;
    for (k = 0; k < pushes; k++) emit(digit_ch($urandom_range(0, 9)));
    for (k = 0; k < pops; k++) emit(any_op());
    if ($urandom_range(0, 3) == 0) emit(8'($urandom_range(0, 255)));
    close_expr();
  endtask

  task automatic emit_noise();
    int len, k;
    len = $urandom_range(1, 12);
    for (k = 0; k < len; k++) begin
      case ($urandom_range(0, 2))
        0:       emit(8'($urandom_range(0, 255)));
        1:       emit(digit_ch($urandom_range(0, 9)));
        default: emit(any_op());
      endcase
    end
    close_expr();
  endtask

  // Build 2^31 from products of eights, then divide the most negative value by -1
  task automatic emit_min_div();
    repeat (2) begin
      emit(digit_ch(8)); emit(digit_ch(8)); emit(pfx_pkg::CH_STAR);
      emit(digit_ch(8)); emit(digit_ch(8)); emit(pfx_pkg::CH_STAR);
      emit(pfx_pkg::CH_STAR);
    end
    emit(pfx_pkg::CH_STAR);
    emit(digit_ch(8)); emit(digit_ch(8)); emit(pfx_pkg::CH_STAR);
    emit(pfx_pkg::CH_STAR);
    emit(digit_ch(2)); emit(pfx_pkg::CH_STAR);
    emit(digit_ch(0)); emit(digit_ch(1)); emit(pfx_pkg::CH_MINUS);
    emit(pfx_pkg::CH_SLASH);
    close_expr();
  endtask

  // Symbol side driver
  always @(posedge clk) begin
    if (rst) begin
      sym_valid <= 1'b0;
      gap_left = 0;
    end else begin
      steady_tail = pend_q.size() < TAIL_BEATS;
      if (sym_valid && sym_ready) begin
        evaluate_symbol(sym_data);
        beats_sent++;
        if (beats_sent % 128 == 0) gap_pct = pick_pct();
      end
      if (!sym_valid || sym_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          sym_valid <= 1'b0;
        end else if (!steady_tail && $urandom_range(0, 99) < gap_pct) begin
          gap_left = $urandom_range(0, 13);
          sym_valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          sym_data  <= pend_q.pop_front();
          sym_valid <= 1'b1;
        end else begin
          sym_valid <= 1'b0;
        end
      end
    end
  end

  // Result side monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_valid && res_ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          log_mismatch($sformatf("unexpected result beat: value %0d status %0d",
                                 res_data.value, res_data.status));
        end else begin
          due = results_due.pop_front();
          if (res_data.value !== due.value)
            log_mismatch($sformatf("result %0d value: got %0d, want %0d",
                                   results_seen, res_data.value, due.value));
          if (res_data.status !== due.status)
            log_mismatch($sformatf("result %0d status: got %0d, want %0d",
                                   results_seen, res_data.status, due.status));
          if (due.status != pfx_pkg::ST_OK) flagged_results++;
        end
        if (results_seen % 16 == 0) stall_pct = pick_pct();
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else if (!steady_tail && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 13);
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Drop out if no beat moves on either side for too long
  always @(posedge clk) begin
    if (rst || (sym_valid && sym_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, results_due.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int directed_beats, k, pick;

    // Fill the stack with every digit, overflow it, then add
    for (k = 9; k >= 0; k--) emit(digit_ch(k));
    emit(digit_ch(5));
    emit(pfx_pkg::CH_PLUS);
    close_expr();
    // ((7 - 3) * 4) / 5
    emit(digit_ch(7)); emit(digit_ch(3)); emit(pfx_pkg::CH_MINUS);
    emit(digit_ch(4)); emit(pfx_pkg::CH_STAR);
    emit(digit_ch(5)); emit(pfx_pkg::CH_SLASH);
    close_expr();
    // Bad character kept over the later underflow
    emit(8'hFF);
    emit(pfx_pkg::CH_SLASH);
    close_expr();
    // Nothing on the stack at the end
    emit(8'h00);
    close_expr();
    emit(digit_ch(5)); emit(digit_ch(0)); emit(pfx_pkg::CH_SLASH);
    close_expr();
    directed_beats = pend_q.size();

    while (pend_q.size() < directed_beats + RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      emit_wellformed();
      else if (pick < 84) emit_broken();
      else if (pick < 97) emit_noise();
      else                emit_min_div();
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pend_q.size() != 0 || sym_valid || results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d symbol beats in %0d expressions (digits, operators, junk bytes).",
             beats_sent, expr_count);
    $display("Checked %0d results, %0d carrying an error status; %0d mismatches.",
             results_seen, flagged_results, fault_count);
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pfx_pkg.sv
rtl/pfx_ram.sv
rtl/pfx_div.sv
rtl/postfix_expression_evaluator_unit.sv
verif/tb_top.sv
